// File: design/cbsr_pkg.sv
// ----------------------------------------------------------------------------
// cbsr_pkg
// Shared constants, codes and control types of the command bus slot reserver.
// ----------------------------------------------------------------------------
package cbsr_pkg;

    localparam int LEN_W         = 20;
    localparam int CNT_W         = 4;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 2;
    localparam int DEF_TRACKED   = 64;
    localparam int DEF_TICK_BITS = 48;
    localparam int CMD_W         = 4;
    localparam int DSEL_W        = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_ROW   = 2'd0;
    localparam logic [OP_W-1:0] OP_COL   = 2'd1;
    localparam logic [OP_W-1:0] OP_PAIR  = 2'd2;
    localparam logic [OP_W-1:0] OP_PRUNE = 2'd3;

    localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_CMDS_PER_WIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_PAIR_GAP  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SET_WIN     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SET_FIRST   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SET_D2      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SET_D1      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PR_SET      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_EVAL_SINGLE = 4'd6;
    localparam logic [CMD_W-1:0] CMD_EVAL_PAIR   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BOOK2       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_BOOK1       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 4'd10;
    localparam logic [CMD_W-1:0] CMD_OUT         = 4'd11;

    localparam logic [DSEL_W-1:0] DSEL_T   = 2'd0;
    localparam logic [DSEL_W-1:0] DSEL_GAP = 2'd1;
    localparam logic [DSEL_W-1:0] DSEL_W2  = 2'd2;
    localparam logic [DSEL_W-1:0] DSEL_W1  = 2'd3;

    typedef struct packed {
        logic              load;
        logic              div_start;
        logic [DSEL_W-1:0] dsel;
        logic [CMD_W-1:0]  code;
    } ctl_t;

    typedef struct packed {
        logic div_busy;
        logic is_prune;
        logic is_pair;
        logic prune_skip;
        logic k_zero;
        logic clr_last;
        logic search_more;
        logic pair_limit;
        logic pair_ok;
        logic out_free;
    } sts_t;

endpackage

// File: design/cbsr_div.sv
// ----------------------------------------------------------------------------
// cbsr_div
// Restoring divider, one quotient bit per cycle, by the window length.
// ----------------------------------------------------------------------------
module cbsr_div #(
    parameter int TICK_BITS = cbsr_pkg::DEF_TICK_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [TICK_BITS-1:0]       dividend,
    input  logic [cbsr_pkg::LEN_W-1:0] divisor,
    output logic                       busy,
    output logic [TICK_BITS-1:0]       quotient,
    output logic [cbsr_pkg::LEN_W-1:0] remainder
);
    import cbsr_pkg::*;

    localparam int CW = $clog2(TICK_BITS + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [TICK_BITS-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [LEN_W-1:0]     div_reg, div_next;
    logic [LEN_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[TICK_BITS-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            cnt_next = CW'(TICK_BITS);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[TICK_BITS-2:0], ge};
            rem_next = ge ? LEN_W'(trial - {1'b0, div_reg}) : trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: design/cbsr_ctrl.sv
// ----------------------------------------------------------------------------
// cbsr_ctrl
// Sequencer: divisions, window search steps, booking, pruning, clearing.
// ----------------------------------------------------------------------------
module cbsr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cbsr_pkg::sts_t sts,
    output logic           in_ready,
    output cbsr_pkg::ctl_t ctl
);
    import cbsr_pkg::*;

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DT_GO   = 5'd2;
    localparam logic [4:0] S_DT_WAIT = 5'd3;
    localparam logic [4:0] S_DG_GO   = 5'd4;
    localparam logic [4:0] S_DG_WAIT = 5'd5;
    localparam logic [4:0] S_D2_GO   = 5'd6;
    localparam logic [4:0] S_D2_WAIT = 5'd7;
    localparam logic [4:0] S_D1_GO   = 5'd8;
    localparam logic [4:0] S_D1_WAIT = 5'd9;
    localparam logic [4:0] S_PR_CHK  = 5'd10;
    localparam logic [4:0] S_READ    = 5'd11;
    localparam logic [4:0] S_EVAL    = 5'd12;
    localparam logic [4:0] S_BK2_RD  = 5'd13;
    localparam logic [4:0] S_BK2_WR  = 5'd14;
    localparam logic [4:0] S_BK1_RD  = 5'd15;
    localparam logic [4:0] S_BK1_WR  = 5'd16;
    localparam logic [4:0] S_CLEAR   = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.code = CMD_CLEAR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DT_GO;
                end
            end
            S_DT_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.dsel      = DSEL_T;
                state_next    = S_DT_WAIT;
            end
            S_DT_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    ctl.code = CMD_SET_WIN;
                    if (sts.is_prune)
                        state_next = S_PR_CHK;
                    else if (sts.is_pair)
                        state_next = S_DG_GO;
                    else
                        state_next = S_D2_GO;
                end
            end
            S_DG_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.dsel      = DSEL_GAP;
                state_next    = S_DG_WAIT;
            end
            S_DG_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    ctl.code   = CMD_SET_FIRST;
                    state_next = S_D2_GO;
                end
            end
            S_PR_CHK:
            begin
                state_next = sts.prune_skip ? S_OUT : S_D2_GO;
            end
            S_D2_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.dsel      = DSEL_W2;
                state_next    = S_D2_WAIT;
            end
            S_D2_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.is_prune)
                    begin
                        ctl.code   = CMD_PR_SET;
                        state_next = sts.k_zero ? S_OUT : S_CLEAR;
                    end
                    else
                    begin
                        ctl.code   = CMD_SET_D2;
                        state_next = sts.is_pair ? S_D1_GO : S_READ;
                    end
                end
            end
            S_D1_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.dsel      = DSEL_W1;
                state_next    = S_D1_WAIT;
            end
            S_D1_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    ctl.code   = CMD_SET_D1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.is_pair)
                begin
                    ctl.code = CMD_EVAL_PAIR;
                    if (sts.pair_limit)
                        state_next = S_OUT;
                    else if (sts.pair_ok)
                        state_next = S_BK2_RD;
                    else
                        state_next = S_READ;
                end
                else
                begin
                    ctl.code   = CMD_EVAL_SINGLE;
                    state_next = sts.search_more ? S_READ : S_BK2_RD;
                end
            end
            S_BK2_RD:
            begin
                state_next = S_BK2_WR;
            end
            S_BK2_WR:
            begin
                ctl.code   = CMD_BOOK2;
                state_next = sts.is_pair ? S_BK1_RD : S_OUT;
            end
            S_BK1_RD:
            begin
                state_next = S_BK1_WR;
            end
            S_BK1_WR:
            begin
                ctl.code   = CMD_BOOK1;
                state_next = S_OUT;
            end
            S_CLEAR:
            begin
                ctl.code = CMD_CLEAR;
                if (sts.clr_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.code   = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

// File: design/cbsr_datapath.sv
// ----------------------------------------------------------------------------
// cbsr_datapath
// Window counters in a ring memory, tick registers, slot trackers, divider
// and the output register.
// ----------------------------------------------------------------------------
module cbsr_datapath #(
    parameter int TRACKED_WINDOWS = cbsr_pkg::DEF_TRACKED,
    parameter int TICK_BITS       = cbsr_pkg::DEF_TICK_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cbsr_pkg::IDX_W-1:0] cfg_index,
    input  logic [cbsr_pkg::LEN_W-1:0] cfg_data,
    input  logic [cbsr_pkg::OP_W-1:0]  in_op,
    input  logic [TICK_BITS-1:0]       in_request_tick,
    input  logic [TICK_BITS-1:0]       in_now_tick,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [TICK_BITS-1:0]       out_issue_tick,
    output logic                       out_range_error,
    input  cbsr_pkg::ctl_t             ctl,
    output cbsr_pkg::sts_t             sts
);
    import cbsr_pkg::*;

    localparam int N          = TRACKED_WINDOWS;
    localparam int TB         = TICK_BITS;
    localparam int AW         = $clog2(N);
    localparam int DW         = $clog2(N + 1);
    localparam int STEP_LIMIT = 3 * N + 8;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam int WW         = 2 * CNT_W;

    // tracker step: {below, slot, next window}
    function automatic logic [TB+DW:0] win_step(input logic [TB-1:0] w, input logic b,
                                                input logic [DW-1:0] d,
                                                input logic [LEN_W-1:0] len,
                                                input logic [TB-1:0] base);
        logic [TB:0]    s;
        logic [TB-1:0]  wn;
        logic           bn;
        logic [DW-1:0]  dn;
        s  = {1'b0, w} + (TB+1)'(len);
        wn = s[TB-1:0];
        if (s[TB] || b)
        begin
            bn = wn < base;
            dn = '0;
        end
        else
        begin
            bn = 1'b0;
            dn = (d == DW'(N)) ? d : DW'(d + 1'b1);
        end
        return {bn, dn, wn};
    endfunction

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] h,
                                                input logic [DW-1:0] d);
        logic [DW:0] s;
        s = (DW+1)'(h) + (DW+1)'(d);
        if (s >= (DW+1)'(N))
            s = s - (DW+1)'(N);
        return s[AW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : CNT_W'(c + 1'b1);
    endfunction

    logic [WW-1:0] mem [N];
    logic [WW-1:0] rda_reg, rdb_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;

    logic [LEN_W-1:0] wlen_reg, wlen_next;
    logic [CNT_W-1:0] cpw_reg, cpw_next;
    logic [LEN_W-1:0] gap_reg, gap_next;
    logic [TB-1:0]    base_reg, base_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [DW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [TB-1:0]    t_reg, t_next;
    logic [TB-1:0]    now_reg, now_next;
    logic [TB-1:0]    at_reg, at_next;
    logic             err_reg, err_next;
    logic [TB-1:0]    w2_reg, w2_next;
    logic [TB-1:0]    w1_reg, w1_next;
    logic [LEN_W-1:0] off_reg, off_next;
    logic             b2_reg, b2_next;
    logic [DW-1:0]    d2_reg, d2_next;
    logic             b1_reg, b1_next;
    logic [DW-1:0]    d1_reg, d1_next;
    logic [TB-1:0]    otick_reg, otick_next;
    logic             oerr_reg, oerr_next;

    logic [LEN_W-1:0] wl;
    logic             div_busy;
    logic [TB-1:0]    quo;
    logic [LEN_W-1:0] rem;
    logic [TB-1:0]    div_in;
    logic [LEN_W-1:0] gap_x;
    logic [LEN_W:0]   back;
    logic [TB-1:0]    back_t;
    logic [TB-1:0]    src;
    logic [DW-1:0]    q_slot;
    logic             q_big;

    logic [AW-1:0]    phys2, phys1;
    logic             in2, in1;
    logic [CNT_W-1:0] rowa, cola, rowb, colb;
    logic [CNT_W-1:0] cnt_single;
    logic [CNT_W:0]   c1, c2, cpw5;
    logic             same, first_ok, second_ok, gap_bad, single_move;
    logic [TB-1:0]    sec_new;
    logic [TB+DW:0]   st2, st1;

    assign wl    = (wlen_reg == '0) ? LEN_W'(1) : wlen_reg;
    assign src   = (op_reg == OP_PRUNE) ? now_reg : t_reg;
    assign gap_x = (gap_reg > off_reg) ? LEN_W'(gap_reg - off_reg) : '0;
    assign back  = (gap_x == '0) ? '0 :
                   (rem == '0) ? {1'b0, gap_x} :
                   (LEN_W+1)'({1'b0, gap_x} - {1'b0, rem} + {1'b0, wl});
    assign back_t = TB'(back);
    assign q_big  = quo >= TB'(N);
    assign q_slot = q_big ? DW'(N) : quo[DW-1:0];

    always_comb
    begin
        unique case (ctl.dsel)
            DSEL_T:   div_in = src;
            DSEL_GAP: div_in = TB'(gap_x);
            DSEL_W2:  div_in = w2_reg - base_reg;
            DSEL_W1:  div_in = w1_reg - base_reg;
            default:  div_in = src;
        endcase
    end

    cbsr_div #(
        .TICK_BITS (TB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_in),
        .divisor   (wl),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    assign phys2 = ring_addr(head_reg, d2_reg);
    assign phys1 = ring_addr(head_reg, d1_reg);
    assign in2   = !b2_reg && (d2_reg < DW'(N));
    assign in1   = !b1_reg && (d1_reg < DW'(N));
    assign rowa  = rda_reg[WW-1:CNT_W];
    assign cola  = rda_reg[CNT_W-1:0];
    assign rowb  = rdb_reg[WW-1:CNT_W];
    assign colb  = rdb_reg[CNT_W-1:0];

    assign st2 = win_step(w2_reg, b2_reg, d2_reg, wl, base_reg);
    assign st1 = win_step(w1_reg, b1_reg, d1_reg, wl, base_reg);

    assign cnt_single  = !in2 ? '0 : ((op_reg == OP_COL) ? cola : rowa);
    assign single_move = (cnt_single >= cpw_reg) && (step_reg <= SW'(N));

    assign cpw5      = {1'b0, cpw_reg};
    assign same      = w2_reg == w1_reg;
    assign c1        = {1'b0, in1 ? rowb : '0};
    assign c2        = same ? (CNT_W+1)'(c1 + 1'b1) : {1'b0, in2 ? rowa : '0};
    assign first_ok  = c1 < cpw5;
    assign second_ok = c2 < cpw5;
    assign sec_new   = second_ok ? w2_reg : st2[TB-1:0];
    assign gap_bad   = !same && ((sec_new - w1_reg) > TB'(gap_reg));

    always_comb
    begin
        sts.div_busy    = div_busy;
        sts.is_prune    = op_reg == OP_PRUNE;
        sts.is_pair     = op_reg == OP_PAIR;
        sts.prune_skip  = w2_reg <= base_reg;
        sts.k_zero      = quo == '0;
        sts.clr_last    = clr_cnt_reg == DW'(1);
        sts.search_more = single_move;
        sts.pair_limit  = step_reg >= SW'(STEP_LIMIT);
        sts.pair_ok     = first_ok && second_ok;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        wlen_next      = wlen_reg;
        cpw_next       = cpw_reg;
        gap_next       = gap_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        step_next      = step_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        t_next         = t_reg;
        now_next       = now_reg;
        at_next        = at_reg;
        err_next       = err_reg;
        w2_next        = w2_reg;
        w1_next        = w1_reg;
        off_next       = off_reg;
        b2_next        = b2_reg;
        d2_next        = d2_reg;
        b1_next        = b1_reg;
        d1_next        = d1_reg;
        otick_next     = otick_reg;
        oerr_next      = oerr_reg;
        mem_we         = 1'b0;
        mem_waddr      = phys2;
        mem_wdata      = rda_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: wlen_next = cfg_data;
                REG_CMDS_PER_WIN:  cpw_next  = cfg_data[CNT_W-1:0];
                REG_MAX_PAIR_GAP:  gap_next  = cfg_data;
                default:           ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (ctl.load)
        begin
            op_next   = in_op;
            t_next    = in_request_tick;
            now_next  = in_now_tick;
            at_next   = in_request_tick;
            err_next  = 1'b0;
            step_next = '0;
        end

        unique case (ctl.code)
            CMD_NONE: ;
            CMD_SET_WIN:
            begin
                w2_next  = src - TB'(rem);
                off_next = rem;
            end
            CMD_SET_FIRST:
            begin
                w1_next = w2_reg - ((back_t < w2_reg) ? back_t : w2_reg);
            end
            CMD_SET_D2:
            begin
                b2_next = w2_reg < base_reg;
                d2_next = q_slot;
            end
            CMD_SET_D1:
            begin
                b1_next = w1_reg < base_reg;
                d1_next = q_slot;
            end
            CMD_PR_SET:
            begin
                clr_addr_next = head_reg;
                base_next     = w2_reg;
                if (q_big)
                    clr_cnt_next = DW'(N);
                else
                begin
                    clr_cnt_next = q_slot;
                    head_next    = ring_addr(head_reg, q_slot);
                end
            end
            CMD_EVAL_SINGLE:
            begin
                if (single_move)
                begin
                    {b2_next, d2_next, w2_next} = st2;
                    at_next   = st2[TB-1:0];
                    step_next = SW'(step_reg + 1'b1);
                end
            end
            CMD_EVAL_PAIR:
            begin
                if (step_reg >= SW'(STEP_LIMIT))
                    err_next = 1'b1;
                else
                begin
                    step_next = SW'(step_reg + 1'b1);
                    if (!second_ok)
                    begin
                        {b2_next, d2_next, w2_next} = st2;
                        at_next = st2[TB-1:0];
                    end
                    if (!first_ok || (!second_ok && gap_bad))
                        {b1_next, d1_next, w1_next} = st1;
                end
            end
            CMD_BOOK2:
            begin
                if (in2)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = phys2;
                    mem_wdata = (op_reg == OP_COL) ? {rowa, sat_inc(cola)}
                                                   : {sat_inc(rowa), cola};
                end
                else
                    err_next = 1'b1;
            end
            CMD_BOOK1:
            begin
                if (in1)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = phys1;
                    mem_wdata = {sat_inc(rowb), colb};
                end
                else
                    err_next = 1'b1;
            end
            CMD_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = ring_addr(clr_addr_reg, DW'(1));
                clr_cnt_next  = DW'(clr_cnt_reg - 1'b1);
            end
            CMD_OUT:
            begin
                out_valid_next = 1'b1;
                otick_next     = (op_reg == OP_PRUNE) ? '0 : at_reg;
                oerr_next      = err_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rda_reg <= mem[phys2];
        rdb_reg <= mem[phys1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= LEN_W'(1);
            cpw_reg       <= CNT_W'(2);
            gap_reg       <= '0;
            base_reg      <= '0;
            head_reg      <= '0;
            step_reg      <= '0;
            clr_cnt_reg   <= DW'(N);
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            cpw_reg       <= cpw_next;
            gap_reg       <= gap_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            step_reg      <= step_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        t_reg     <= t_next;
        now_reg   <= now_next;
        at_reg    <= at_next;
        err_reg   <= err_next;
        w2_reg    <= w2_next;
        w1_reg    <= w1_next;
        off_reg   <= off_next;
        b2_reg    <= b2_next;
        d2_reg    <= d2_next;
        b1_reg    <= b1_next;
        d1_reg    <= d1_next;
        otick_reg <= otick_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_issue_tick  = otick_reg;
    assign out_range_error = oerr_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SW'(STEP_LIMIT))
        else $error("search step count beyond limit");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.code == CMD_CLEAR) |-> (clr_cnt_reg != '0))
        else $error("clear sweep with no entries left");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < AW'(N) || N == (1 << AW))
        else $error("ring head outside ring");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.code == CMD_CLEAR && clr_cnt_reg == DW'(1)) |=> (clr_cnt_reg == '0))
        else $error("clear sweep did not finish");

endmodule

// File: design/command_bus_slot_reserver.sv
// ----------------------------------------------------------------------------
// command_bus_slot_reserver
// Books row and column command slots per time window on a memory command bus.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per beat (single row, single column,
//   paired row, or prune). Every accepted beat produces exactly one output
//   beat with the issue tick and a range error flag (zero for prune).
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
//   Each request runs several divisions on a bit-serial divider, then, for
//   row, column and pair requests, a counter search that reads the window
//   counters and then evaluates them at each step; a prune instead sweeps the
//   dropped windows to zero. The divider and the counter search set the time
//   taken; the block handles one item at a time.
//   After reset the counter memory is swept to zero, one entry per cycle
//   (all TRACKED_WINDOWS entries) with s_axis_tready low.
//   The result sits in an output register; a stalled receiver blocks only the
//   completion of the following item, which waits until the register frees.
// ----------------------------------------------------------------------------
module command_bus_slot_reserver #(
    parameter int TRACKED_WINDOWS = cbsr_pkg::DEF_TRACKED,
    parameter int TICK_BITS       = cbsr_pkg::DEF_TICK_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cbsr_pkg::IDX_W-1:0] cfg_index,
    input  logic [cbsr_pkg::LEN_W-1:0] cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // op, request_tick, now_tick, zero pad
    input  logic [((cbsr_pkg::OP_W + 2*TICK_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // issue_tick, range_error, zero pad
    output logic [((TICK_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import cbsr_pkg::*;

    localparam int OUT_W = ((TICK_BITS + 1 + 7) / 8) * 8;

    ctl_t                 ctl;
    sts_t                 sts;
    logic [TICK_BITS-1:0] issue_tick;
    logic                 range_error;

    cbsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .ctl      (ctl)
    );

    cbsr_datapath #(
        .TRACKED_WINDOWS (TRACKED_WINDOWS),
        .TICK_BITS       (TICK_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_op           (s_axis_tdata[OP_W-1:0]),
        .in_request_tick (s_axis_tdata[OP_W+TICK_BITS-1:OP_W]),
        .in_now_tick     (s_axis_tdata[OP_W+2*TICK_BITS-1:OP_W+TICK_BITS]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_issue_tick  (issue_tick),
        .out_range_error (range_error),
        .ctl             (ctl),
        .sts             (sts)
    );

    assign m_axis_tdata = OUT_W'({range_error, issue_tick});

endmodule

// File: sim/cbsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbsr_checker
// Watches the configuration port and both streams of the slot reserver,
// keeps its own copy of the window counters and predicts every output beat.
// ----------------------------------------------------------------------------
module cbsr_checker
    import cbsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [103:0]     s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [55:0]      m_axis_tdata,
    output int               errors,
    output int               pending
);

    localparam int RING = DEF_TRACKED;
    localparam int PAIR_STEPS = 3 * RING + 8;
    localparam bit [63:0] TMASK = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct {
        bit [47:0] issue;
        bit        rerr;
    } slot_result_t;

    slot_result_t issue_q[$];

    bit [CNT_W-1:0] row_cnt[RING];
    bit [CNT_W-1:0] col_cnt[RING];
    bit [63:0]      base_tick;
    bit [63:0]      win_len;
    bit [63:0]      cmds_max;
    bit [63:0]      gap_max;

    function automatic bit [63:0] wl_eff();
        return (win_len == 0) ? 64'd1 : win_len;
    endfunction

    function automatic bit [63:0] window_start(bit [63:0] t);
        return t - (t % wl_eff());
    endfunction

    function automatic bit [63:0] step_window(bit [63:0] w);
        return (w + wl_eff()) & TMASK;
    endfunction

    function automatic int ring_slot(bit [63:0] w);
        bit [63:0] d;
        if (w < base_tick)
            return -1;
        d = (w - base_tick) / wl_eff();
        if (d >= RING)
            return -1;
        return int'(d);
    endfunction

    function automatic bit [63:0] booked(bit col, bit [63:0] w);
        int s;
        s = ring_slot(w);
        if (s < 0)
            return 0;
        return col ? col_cnt[s] : row_cnt[s];
    endfunction

    function automatic bit book_slot(bit col, bit [63:0] w);
        int s;
        s = ring_slot(w);
        if (s < 0)
            return 0;
        if (col) begin
            if (col_cnt[s] != CNT_MAX)
                col_cnt[s]++;
        end
        else begin
            if (row_cnt[s] != CNT_MAX)
                row_cnt[s]++;
        end
        return 1;
    endfunction

    function automatic bit [63:0] place_single(bit col, bit [63:0] t, inout bit err);
        bit [63:0] at;
        bit [63:0] w;
        int        i;
        at = t;
        w  = window_start(t);
        i  = 0;
        while (i <= RING && booked(col, w) >= cmds_max) begin
            w  = step_window(w);
            at = w;
            i++;
        end
        if (!book_slot(col, w))
            err = 1;
        return at;
    endfunction

    function automatic bit [63:0] place_pair(bit [63:0] t, inout bit err);
        bit [63:0] at, second, first, wl, off, back, c1, c2;
        bit        first_ok, second_ok, same, gap_bad;
        int        steps;
        at        = t;
        second    = window_start(t);
        wl        = wl_eff();
        off       = t % wl;
        back      = 0;
        first_ok  = 0;
        second_ok = 0;
        steps     = 0;
        if (gap_max > off)
            back = ((gap_max - off + wl - 1) / wl) * wl;
        first = second - ((back < second) ? back : second);
        while (!first_ok || !second_ok) begin
            same = (second == first);
            if (steps >= PAIR_STEPS) begin
                err = 1;
                return at;
            end
            steps++;
            c1 = booked(0, first);
            c2 = same ? c1 + 1 : booked(0, second);
            first_ok  = c1 < cmds_max;
            second_ok = c2 < cmds_max;
            if (!second_ok) begin
                second = step_window(second);
                at     = second;
            end
            gap_bad = !same && (((second - first) & TMASK) > gap_max);
            if (!first_ok || (!second_ok && gap_bad))
                first = step_window(first);
        end
        if (!book_slot(0, second))
            err = 1;
        if (!book_slot(0, first))
            err = 1;
        return at;
    endfunction

    function automatic void advance_base(bit [63:0] now);
        bit [63:0] nb, k;
        nb = window_start(now);
        if (nb <= base_tick)
            return;
        k = (nb - base_tick) / wl_eff();
        for (int i = 0; i < RING; i++) begin
            if (k < RING && i + k < RING) begin
                row_cnt[i] = row_cnt[i + int'(k)];
                col_cnt[i] = col_cnt[i + int'(k)];
            end
            else begin
                row_cnt[i] = 0;
                col_cnt[i] = 0;
            end
        end
        base_tick = nb;
    endfunction

    function automatic slot_result_t predict_beat(bit [1:0] op, bit [63:0] t, bit [63:0] now);
        slot_result_t r;
        bit           err;
        bit [63:0]    at;
        err = 0;
        at  = 0;
        case (op)
            OP_ROW:  at = place_single(0, t, err);
            OP_COL:  at = place_single(1, t, err);
            OP_PAIR: at = place_pair(t, err);
            default: advance_base(now);
        endcase
        r.issue = at[47:0];
        r.rerr  = err;
        return r;
    endfunction

    assign pending = issue_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t exp_r;
        if (!rst_n) begin
            for (int i = 0; i < RING; i++) begin
                row_cnt[i] = 0;
                col_cnt[i] = 0;
            end
            base_tick = 0;
            win_len   = 1;
            cmds_max  = 2;
            gap_max   = 0;
            errors    = 0;
            issue_q.delete();
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: win_len  = cfg_data;
                    REG_CMDS_PER_WIN:  cmds_max = cfg_data[CNT_W-1:0];
                    REG_MAX_PAIR_GAP:  gap_max  = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                issue_q.push_back(predict_beat(s_axis_tdata[1:0],
                                               {16'd0, s_axis_tdata[49:2]},
                                               {16'd0, s_axis_tdata[97:50]}));
            if (m_axis_tvalid && m_axis_tready) begin
                if (issue_q.size() == 0) begin
                    $error("output beat with no request outstanding: %0h", m_axis_tdata);
                    errors++;
                end
                else begin
                    exp_r = issue_q.pop_front();
                    if (m_axis_tdata[47:0] !== exp_r.issue) begin
                        $error("issue_tick mismatch: expected %0h, got %0h",
                               exp_r.issue, m_axis_tdata[47:0]);
                        errors++;
                    end
                    if (m_axis_tdata[48] !== exp_r.rerr) begin
                        $error("range_error mismatch: expected %0b, got %0b",
                               exp_r.rerr, m_axis_tdata[48]);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// File: sim/command_bus_slot_reserver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_bus_slot_reserver_tb
// Drives the slot reserver through several register settings with directed
// and random requests and prunes, random stalls on both streams, and leaves
// all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module command_bus_slot_reserver_tb;
    import cbsr_pkg::*;

    localparam bit [63:0] TMASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0] cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // op, request_tick, now_tick, zero pad
    logic [103:0]     s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // issue_tick, range_error, zero pad
    logic [55:0]      m_axis_tdata;

    int        errors;
    int        pending;
    int        cycles;
    bit        calm;
    bit [63:0] cur_tick;
    bit [63:0] cur_wl;

    command_bus_slot_reserver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cbsr_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, bit [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[LEN_W-1:0];
        @(posedge clk);
    endtask

    task automatic send_beat(logic [OP_W-1:0] op, bit [63:0] req, bit [63:0] now);
        if (!calm && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, now[47:0], req[47:0], op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // drain, then settle before touching the registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_window(bit [63:0] wl, bit [63:0] cpw, bit [63:0] gap);
        drain();
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_CMDS_PER_WIN, cpw);
        write_reg(REG_MAX_PAIR_GAP, gap);
        cfg_wr_en <= 1'b0;
        cur_wl = (wl == 0) ? 1 : wl;
    endtask

    task automatic random_beats(int n);
        int        r;
        bit [63:0] req;
        bit [63:0] now;
        logic [OP_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            r   = $urandom_range(0, 99);
            now = {$urandom, $urandom} & TMASK;
            req = (cur_tick + $urandom_range(0, 70) * cur_wl
                   + $urandom_range(0, int'(cur_wl - 1))) & TMASK;
            if (r < 8) begin
                op  = OP_W'($urandom_range(0, 2));
                req = {$urandom, $urandom} & TMASK;
            end
            else if (r < 40)
                op = OP_ROW;
            else if (r < 58)
                op = OP_COL;
            else if (r < 88)
                op = OP_PAIR;
            else begin
                op = OP_PRUNE;
                if ($urandom_range(0, 4) == 0)
                    now = (cur_tick - $urandom_range(0, 3) * cur_wl) & TMASK;
                else begin
                    cur_tick = (cur_tick + $urandom_range(0, 6) * cur_wl
                                + $urandom_range(0, int'(cur_wl - 1))) & TMASK;
                    now = cur_tick;
                end
            end
            send_beat(op, req, now);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        calm          = 1'b0;
        cur_tick      = 0;
        cur_wl        = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_window(1, 2, 0);
        repeat (3) send_beat(OP_ROW, 0, 0);
        repeat (3) send_beat(OP_COL, 0, 0);
        repeat (2) send_beat(OP_PAIR, 0, 0);
        send_beat(OP_ROW, TMASK, 0);
        send_beat(OP_COL, TMASK, TMASK);
        send_beat(OP_PAIR, TMASK, 0);
        send_beat(OP_PRUNE, 0, 5);
        send_beat(OP_PRUNE, 0, 2);
        send_beat(OP_ROW, 3, 0);
        send_beat(OP_ROW, 100, 0);
        send_beat(OP_PRUNE, 0, 1000);
        send_beat(OP_ROW, 1000, 0);
        repeat (3) send_beat(OP_PAIR, 1001, 0);
        send_beat(OP_COL, 1063, 0);
        send_beat(OP_COL, 1064, 0);
        cur_tick = 1000;
        random_beats(110);

        set_window(1048575, 15, 1048575);
        random_beats(130);

        set_window(0, 1, 0);
        random_beats(130);

        set_window(16, 0, 40);
        random_beats(100);

        set_window(7, 3, 25);
        calm = 1'b1;
        random_beats(130);
        calm = 1'b0;

        set_window(1000, 4, 2500);
        random_beats(130);

        set_window(3, 2, 1048575);
        random_beats(130);

        // wrap at the top of the tick range
        set_window(1, 15, 0);
        cur_tick = TMASK - 40;
        send_beat(OP_PRUNE, 0, cur_tick);
        random_beats(130);

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/cbsr_pkg.sv
design/cbsr_div.sv
design/cbsr_ctrl.sv
design/cbsr_datapath.sv
design/command_bus_slot_reserver.sv
sim/cbsr_checker.sv
sim/command_bus_slot_reserver_tb.sv
